>>> rtl/core/aatrm_pkg.sv
`default_nettype none
package aatrm_pkg;

  // angle constants, degrees in Q10.6
  localparam int FULL_TURN_LSB = 23040;
  localparam int HALF_TURN_LSB = 11520;
  // pi / 23040 in Q40, and the inverse CORDIC gain in Q30
  localparam logic [27:0] HALF_RAD_Q40 = 28'd149922641;
  localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;

  localparam int IN_W  = 64;
  localparam int OUT_W = 120;
  localparam int ENT_W = 18;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [ENT_W-1:0] ent_t;

  // arctangent of 2^-i in Q30
  localparam logic signed [63:0] ATAN_Q30 [11] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
    64'sd4194283, 64'sd2097149, 64'sd1048576
  };

  // arithmetic shift right with round half up
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< ((s > 0) ? (s - 1) : 0);
    if (s == 0) begin
      rnd = v;
    end else begin
      rnd = (v + bias) >>> s;
    end
  endfunction

  function automatic logic signed [63:0] atan_fix(input int i, input int drop);
    logic signed [63:0] a;
    if (i <= 10) begin
      a = ATAN_Q30[i];
    end else if (i <= 30) begin
      a = 64'sd1 <<< (30 - i);
    end else begin
      a = 64'sd0;
    end
    atan_fix = rnd(a, drop);
  endfunction

  function automatic q15_t sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // Q30 matrix term to saturated Q3.15
  function automatic ent_t ent(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + 35'sd16384) >>> 15;
    if (t > 35'sd131071) begin
      ent = 18'sh1ffff;
    end else if (t < -35'sd131072) begin
      ent = 18'sh20000;
    end else begin
      ent = t[ENT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/aatrm_cordic.sv
`default_nettype none
module aatrm_cordic
  import aatrm_pkg::*;
#(
  parameter int STEPS = 16,
  parameter int FB    = 15,
  parameter int TAG_W = 49
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [FB+2:0] in_z,
  input  wire logic [TAG_W-1:0]    in_tag,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [FB+2:0]     out_x,
  output logic signed [FB+2:0]     out_y,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int W    = FB + 3;
  localparam int DROP = 30 - FB;
  localparam logic signed [63:0] GAIN_FIX = rnd(GAIN_Q30, DROP);

  logic signed [W-1:0] x_r [STEPS+1];
  logic signed [W-1:0] y_r [STEPS+1];
  logic signed [W-1:0] z_r [STEPS+1];
  logic [TAG_W-1:0]    tag_r [STEPS+1];
  logic [STEPS:0]      vld_r;
  logic [STEPS+1:0]    rdy;

  // per-stage ready, bubbles collapse
  always_comb begin
    rdy[STEPS+1] = out_ready;
    for (int k = STEPS; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STEPS];
  assign out_x     = x_r[STEPS];
  assign out_y     = y_r[STEPS];
  assign out_tag   = tag_r[STEPS];

  // entry stage: load angle and gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      x_r[0]   <= GAIN_FIX[W-1:0];
      y_r[0]   <= '0;
      z_r[0]   <= in_z;
      tag_r[0] <= in_tag;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [63:0] ATAN_I = atan_fix(i, DROP);
    logic signed [W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (rdy[i+1]) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (rdy[i+1]) begin
        tag_r[i+1] <= tag_r[i];
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I[W-1:0];
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I[W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/axis_angle_to_rotation_matrix.sv
`default_nettype none
// Each item leaves as three row beats on the result channel, and the
// serializer takes a new item only with the last row beat of the one before;
// the pipeline takes a new item each cycle until it fills.
// Reset (synchronous, active low) clears all valid bits and the row counter;
// data registers are not reset.
module axis_angle_to_rotation_matrix
  import aatrm_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 15
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // axis_x[15:0], axis_y[31:16], axis_z[47:32], angle_degrees[63:48]
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // row_index[1:0], entry_first[19:2], entry_second[37:20], entry_third[55:38],
  // quat_w[71:56], quat_x[87:72], quat_y[103:88], quat_z[119:104]
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast
);

  localparam int W     = FRACTION_BITS + 3;
  localparam int DROP  = 30 - FRACTION_BITS;
  localparam int SH_DN = (FRACTION_BITS >= 15) ? FRACTION_BITS - 15 : 0;
  localparam int SH_UP = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 0;
  localparam int TAG_W = 49;

  // ---------------- stage 1: angle reduction ----------------
  logic signed [16:0] ang, red;
  logic               v1_r, neg1_r;
  logic [13:0]        mag1_r;
  logic [47:0]        axes1_r;
  logic               rdy1, rdy2, c_in_rdy;

  assign ang = {in_tdata[63], in_tdata[63:48]};

  always_comb begin
    if (ang > 17'(HALF_TURN_LSB)) begin
      red = ang - 17'(FULL_TURN_LSB);
    end else if (ang <= -17'sd11520) begin
      red = ang + 17'(FULL_TURN_LSB);
    end else begin
      red = ang;
    end
  end

  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
    if (rdy1) begin
      neg1_r  <= red[16];
      mag1_r  <= red[16] ? 14'(-red) : red[13:0];
      axes1_r <= in_tdata[47:0];
    end
  end

  // ---------------- stage 2: degrees to radians ----------------
  logic        v2_r, neg2_r;
  logic [41:0] prod2_r;
  logic [47:0] axes2_r;

  assign rdy1 = !v1_r || rdy2;
  assign rdy2 = !v2_r || c_in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2) begin
      prod2_r <= 42'(mag1_r) * 42'(HALF_RAD_Q40);
      neg2_r  <= neg1_r;
      axes2_r <= axes1_r;
    end
  end

  // half angle Q30, then to datapath width
  logic [31:0]          half_q30;
  logic signed [63:0]   z0_full;
  assign half_q30 = 32'((prod2_r + 42'd512) >> 10);
  assign z0_full  = rnd($signed({32'd0, half_q30}), DROP);

  // ---------------- CORDIC ----------------
  logic                c_vld, rdy4;
  logic signed [W-1:0] c_x, c_y;
  logic [TAG_W-1:0]    c_tag;

  aatrm_cordic #(
    .STEPS (CORDIC_STEPS),
    .FB    (FRACTION_BITS),
    .TAG_W (TAG_W)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (c_in_rdy),
    .in_z      (z0_full[W-1:0]),
    .in_tag    ({neg2_r, axes2_r}),
    .out_valid (c_vld),
    .out_ready (rdy4),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_tag   (c_tag)
  );

  // ---------------- stage 4: sine and cosine to Q1.15 ----------------
  logic               v4_r, rdy5;
  q15_t               w4_r;
  logic signed [16:0] sn4_r;
  logic [47:0]        axes4_r;
  q15_t               cq, sq;

  always_comb begin
    if (FRACTION_BITS >= 15) begin
      cq = sat16(rnd(64'(c_x), SH_DN));
      sq = sat16(rnd(64'(c_y), SH_DN));
    end else begin
      cq = sat16(64'(c_x) <<< SH_UP);
      sq = sat16(64'(c_y) <<< SH_UP);
    end
  end

  assign rdy4 = !v4_r || rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= c_vld;
    end
    if (rdy4) begin
      w4_r    <= cq;
      sn4_r   <= c_tag[48] ? -17'(sq) : 17'(sq);
      axes4_r <= c_tag[47:0];
    end
  end

  // ---------------- stage 5: quaternion ----------------
  logic v5_r, rdy6;
  q15_t w5_r, x5_r, y5_r, z5_r;
  logic signed [32:0] px, py, pz;

  assign px = $signed(axes4_r[15:0]) * sn4_r;
  assign py = $signed(axes4_r[31:16]) * sn4_r;
  assign pz = $signed(axes4_r[47:32]) * sn4_r;
  assign rdy5 = !v5_r || rdy6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
    if (rdy5) begin
      w5_r <= w4_r;
      x5_r <= sat16(rnd(64'(px), 15));
      y5_r <= sat16(rnd(64'(py), 15));
      z5_r <= sat16(rnd(64'(pz), 15));
    end
  end

  // ---------------- stage 6: quaternion products ----------------
  logic v6_r, ser_rdy;
  q15_t w6_r, x6_r, y6_r, z6_r;
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;

  assign rdy6 = !v6_r || ser_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= v5_r;
    end
    if (rdy6) begin
      w6_r <= w5_r;
      x6_r <= x5_r;
      y6_r <= y5_r;
      z6_r <= z5_r;
      xx_r <= x5_r * x5_r;
      yy_r <= y5_r * y5_r;
      zz_r <= z5_r * z5_r;
      xy_r <= x5_r * y5_r;
      xz_r <= x5_r * z5_r;
      yz_r <= y5_r * z5_r;
      xw_r <= x5_r * w5_r;
      yw_r <= y5_r * w5_r;
      zw_r <= z5_r * w5_r;
    end
  end

  // ---------------- stage 7: matrix entries, row serializer ----------------
  localparam logic signed [34:0] ONE_Q30 = 35'sd1 <<< 30;

  function automatic logic signed [34:0] diag(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    diag = ONE_Q30 - ((35'(a) + 35'(b)) <<< 1);
  endfunction

  function automatic logic signed [34:0] offd(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic sub);
    offd = sub ? ((35'(a) - 35'(b)) <<< 1) : ((35'(a) + 35'(b)) <<< 1);
  endfunction

  logic       ser_vld_r;
  logic [1:0] row_r;
  ent_t       e_r [9];
  q15_t       qw_r, qx_r, qy_r, qz_r;
  logic       last_beat;

  assign last_beat = (row_r == 2'd2);
  assign ser_rdy   = !ser_vld_r || (out_tready && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      row_r     <= 2'd0;
    end else if (ser_rdy) begin
      ser_vld_r <= v6_r;
      row_r     <= 2'd0;
    end else if (out_tready) begin
      row_r <= row_r + 2'd1;
    end
    if (ser_rdy) begin
      qw_r   <= w6_r;
      qx_r   <= x6_r;
      qy_r   <= y6_r;
      qz_r   <= z6_r;
      e_r[0] <= ent(diag(yy_r, zz_r));
      e_r[1] <= ent(offd(xy_r, zw_r, 1'b0));
      e_r[2] <= ent(offd(xz_r, yw_r, 1'b1));
      e_r[3] <= ent(offd(xy_r, zw_r, 1'b1));
      e_r[4] <= ent(diag(xx_r, zz_r));
      e_r[5] <= ent(offd(yz_r, xw_r, 1'b0));
      e_r[6] <= ent(offd(xz_r, yw_r, 1'b0));
      e_r[7] <= ent(offd(yz_r, xw_r, 1'b1));
      e_r[8] <= ent(diag(xx_r, yy_r));
    end
  end

  // row select
  ent_t e1, e2, e3;
  always_comb begin
    case (row_r)
      2'd0: begin
        e1 = e_r[0]; e2 = e_r[1]; e3 = e_r[2];
      end
      2'd1: begin
        e1 = e_r[3]; e2 = e_r[4]; e3 = e_r[5];
      end
      default: begin
        e1 = e_r[6]; e2 = e_r[7]; e3 = e_r[8];
      end
    endcase
  end

  assign out_tvalid = ser_vld_r;
  assign out_tlast  = last_beat;
  assign out_tdata  = {qz_r, qy_r, qx_r, qw_r, e3, e2, e1, row_r};

endmodule
`default_nettype wire
